// ----- src/alal_pkg.sv -----
// Shared types and constants of the array linked list engine.
`timescale 1ns / 1ps
`default_nettype none

package alal_pkg;

    localparam int DATA_W = 32;
    localparam int LINK_W = 8;
    localparam int POS_W  = 7;

    localparam logic [LINK_W-1:0] LINK_END  = 8'd254;
    localparam logic [LINK_W-1:0] LINK_FREE = 8'd255;

    typedef enum logic [1:0] {
        FUNC_INIT,
        FUNC_INSERT,
        FUNC_DELETE,
        FUNC_TRAVERSE
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ILLEGAL,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_HEAD_RD,
        S_HEAD,
        S_WALK,
        S_FREE_RD,
        S_FREE_CK,
        S_INS_A,
        S_INS_B,
        S_TGT,
        S_DEL_A,
        S_DEL_B,
        S_TRAV
    } t_state;

    // Flags and counts from the shared link/count unit.
    typedef struct packed {
        logic              link_end;
        logic              link_free;
        logic              cnt_zero;
        logic              cnt_last;
        logic [LINK_W-1:0] cnt_inc;
        logic [LINK_W-1:0] cnt_dec;
    } t_step;

    // One result transaction.
    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] value;
        logic [LINK_W-1:0] next;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ----- src/alal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module alal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/alal_step.sv -----
// Shared link compare and counter step unit of the list sequencer.
`timescale 1ns / 1ps
`default_nettype none

module alal_step #(
    parameter int SLOTS = 64
) (
    input  wire logic [alal_pkg::LINK_W-1:0] i_link,
    input  wire logic [alal_pkg::LINK_W-1:0] i_cnt,
    output alal_pkg::t_step                  o_step
);

    localparam logic [alal_pkg::LINK_W-1:0] SlotsW = alal_pkg::LINK_W'(SLOTS);
    localparam logic [alal_pkg::LINK_W-1:0] LastW  = alal_pkg::LINK_W'(SLOTS - 1);

    always_comb begin
        o_step.link_end  = (i_link >= SlotsW);
        o_step.link_free = (i_link == alal_pkg::LINK_FREE);
        o_step.cnt_zero  = (i_cnt == '0);
        o_step.cnt_last  = (i_cnt == LastW);
        o_step.cnt_inc   = i_cnt + 8'd1;
        o_step.cnt_dec   = i_cnt - 8'd1;
    end

endmodule

`default_nettype wire

// ----- src/array_linked_list_engine.sv -----
// Top level of the array linked list engine: command sequencer and slot store.
`timescale 1ns / 1ps
`default_nettype none

// A singly linked list kept in SLOTS slots, slot 0 always the head. A command
// transaction is taken when start is high and busy is low; busy then stays
// high until the command's last result is out. Results come from an output
// register, one transaction per o_valid cycle, and the receiver cannot stall
// them: sample every cycle in which o_valid is high. o_last marks the final
// result of a command. Insert, delete and traverse first read the head (an
// empty list answers there). The position walk then takes position - 1
// steps for position 2 and up, every step one link read from the single
// read port of the link RAM. Insert adds a free-slot scan that probes each
// slot by a read and then a compare, up to SLOTS slots, plus two writes;
// delete adds a target read and two writes, or one write when the only node
// goes. Traverse streams one node per cycle after the head read. No clearing
// pass after reset is needed: each slot carries a valid bit in flip-flops,
// cleared by reset and by init, and a link that is not valid reads as free.
// busy drops in the cycle the last result is shown, so the next command may
// be issued then.
module array_linked_list_engine #(
    parameter int SLOTS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_func,
    input  wire logic signed [alal_pkg::DATA_W-1:0] i_value,
    input  wire logic [alal_pkg::POS_W-1:0]     i_position,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic signed [alal_pkg::DATA_W-1:0]  o_node_value,
    output logic [alal_pkg::LINK_W-1:0]         o_node_next,
    output logic                                o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = alal_pkg::DATA_W;
    localparam int LW = alal_pkg::LINK_W;
    localparam int PW = alal_pkg::POS_W;
    localparam logic [LW-1:0] SlotsW = LW'(SLOTS);

    // Control state.
    alal_pkg::t_state  r_state, n_state;
    logic [SLOTS-1:0]  r_vbits, n_vbits;
    logic              r_rd_vld;
    logic              r_valid, n_valid;
    logic [LW-1:0]     r_cnt, n_cnt;

    // Payload state.
    alal_pkg::t_func   r_func, n_func;
    logic [DW-1:0]     r_value, n_value;
    logic [PW-1:0]     r_pos, n_pos;
    logic [IW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_pred, n_pred;
    logic [LW-1:0]     r_plink, n_plink;
    logic [DW-1:0]     r_head_data, n_head_data;
    logic [LW-1:0]     r_head_link, n_head_link;
    logic [LW-1:0]     r_tgt, n_tgt;
    logic [DW-1:0]     r_tdata, n_tdata;
    logic [LW-1:0]     r_tlink, n_tlink;
    logic [IW-1:0]     r_fidx, n_fidx;
    alal_pkg::t_result r_res, n_res;

    // Store ports.
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic              data_we, link_we;
    logic [DW-1:0]     data_wdata, data_q;
    logic [LW-1:0]     link_wdata, link_raw, link_q;

    alal_pkg::t_step   step;
    logic              accept, pos_one;

    alal_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (wr_addr),
        .i_wdata (data_wdata),
        .i_raddr (rd_addr),
        .o_rdata (data_q)
    );

    alal_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (wr_addr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_raw)
    );

    // A slot never written since init or reset reads as free.
    assign link_q = r_rd_vld ? link_raw : alal_pkg::LINK_FREE;

    alal_step #(.SLOTS(SLOTS)) u_step (
        .i_link (link_q),
        .i_cnt  (r_cnt),
        .o_step (step)
    );

    assign busy         = (r_state != alal_pkg::S_IDLE);
    assign accept       = start && !busy;
    assign pos_one      = (r_pos == PW'(1));
    assign o_valid      = r_valid;
    assign o_status     = r_res.status;
    assign o_node_value = r_res.value;
    assign o_node_next  = r_res.next;
    assign o_last       = r_res.last;

    always_comb begin
        n_state     = r_state;
        n_vbits     = r_vbits;
        n_valid     = 1'b0;
        n_cnt       = r_cnt;
        n_func      = r_func;
        n_value     = r_value;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_pred      = r_pred;
        n_plink     = r_plink;
        n_head_data = r_head_data;
        n_head_link = r_head_link;
        n_tgt       = r_tgt;
        n_tdata     = r_tdata;
        n_tlink     = r_tlink;
        n_fidx      = r_fidx;
        n_res       = r_res;
        rd_addr     = '0;
        wr_addr     = '0;
        data_we     = 1'b0;
        link_we     = 1'b0;
        data_wdata  = r_value;
        link_wdata  = alal_pkg::LINK_FREE;

        case (r_state)
            alal_pkg::S_IDLE: begin
                if (accept) begin
                    n_func  = alal_pkg::t_func'(i_func);
                    n_value = i_value;
                    n_pos   = i_position;
                    n_state = (alal_pkg::t_func'(i_func) == alal_pkg::FUNC_INIT)
                            ? alal_pkg::S_INIT : alal_pkg::S_HEAD_RD;
                end
            end

            alal_pkg::S_INIT: begin
                // Free every slot, then store the one-node list in slot 0.
                n_vbits    = '0;
                wr_addr    = '0;
                data_we    = 1'b1;
                link_we    = 1'b1;
                data_wdata = r_value;
                link_wdata = alal_pkg::LINK_END;
                n_valid    = 1'b1;
                n_res      = '{alal_pkg::ST_OK, '0, '0, 1'b1};
                n_state    = alal_pkg::S_IDLE;
            end

            alal_pkg::S_HEAD_RD: begin
                rd_addr = '0;
                n_state = alal_pkg::S_HEAD;
            end

            alal_pkg::S_HEAD: begin
                n_head_link = link_q;
                n_head_data = data_q;
                if (step.link_free) begin
                    n_valid = 1'b1;
                    n_res   = '{alal_pkg::ST_EMPTY, '0, '0, 1'b1};
                    n_state = alal_pkg::S_IDLE;
                end else begin
                    case (r_func)
                        alal_pkg::FUNC_TRAVERSE: begin
                            rd_addr = '0;
                            n_cnt   = '0;
                            n_state = alal_pkg::S_TRAV;
                        end
                        alal_pkg::FUNC_INSERT, alal_pkg::FUNC_DELETE: begin
                            if (r_pos == '0) begin
                                n_valid = 1'b1;
                                n_res   = '{alal_pkg::ST_ILLEGAL, '0, '0, 1'b1};
                                n_state = alal_pkg::S_IDLE;
                            end else if (pos_one) begin
                                if (r_func == alal_pkg::FUNC_INSERT) begin
                                    n_cnt   = '0;
                                    n_state = alal_pkg::S_FREE_RD;
                                end else if (step.link_end) begin
                                    // Sole node goes: clear slot 0, skip the free step.
                                    n_tgt   = link_q;
                                    n_tlink = alal_pkg::LINK_FREE;
                                    n_tdata = '0;
                                    n_state = alal_pkg::S_DEL_A;
                                end else begin
                                    n_tgt   = link_q;
                                    rd_addr = link_q[IW-1:0];
                                    n_state = alal_pkg::S_TGT;
                                end
                            end else begin
                                // Walk position - 2 links to the predecessor.
                                n_cnt   = LW'(r_pos) - 8'd2;
                                n_cur   = '0;
                                rd_addr = '0;
                                n_state = alal_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = alal_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            alal_pkg::S_WALK: begin
                if (step.cnt_zero) begin
                    n_pred  = r_cur;
                    n_plink = link_q;
                    if (r_func == alal_pkg::FUNC_INSERT) begin
                        n_cnt   = '0;
                        n_state = alal_pkg::S_FREE_RD;
                    end else if (step.link_end) begin
                        n_valid = 1'b1;
                        n_res   = '{alal_pkg::ST_ILLEGAL, '0, '0, 1'b1};
                        n_state = alal_pkg::S_IDLE;
                    end else begin
                        n_tgt   = link_q;
                        rd_addr = link_q[IW-1:0];
                        n_state = alal_pkg::S_TGT;
                    end
                end else if (step.link_end) begin
                    n_valid = 1'b1;
                    n_res   = '{alal_pkg::ST_ILLEGAL, '0, '0, 1'b1};
                    n_state = alal_pkg::S_IDLE;
                end else begin
                    n_cur   = link_q[IW-1:0];
                    rd_addr = link_q[IW-1:0];
                    n_cnt   = step.cnt_dec;
                end
            end

            alal_pkg::S_FREE_RD: begin
                rd_addr = r_cnt[IW-1:0];
                n_state = alal_pkg::S_FREE_CK;
            end

            alal_pkg::S_FREE_CK: begin
                if (step.link_free) begin
                    n_fidx  = r_cnt[IW-1:0];
                    n_state = alal_pkg::S_INS_A;
                end else if (step.cnt_last) begin
                    n_valid = 1'b1;
                    n_res   = '{alal_pkg::ST_FULL, '0, '0, 1'b1};
                    n_state = alal_pkg::S_IDLE;
                end else begin
                    n_cnt   = step.cnt_inc;
                    n_state = alal_pkg::S_FREE_RD;
                end
            end

            alal_pkg::S_INS_A: begin
                // Fill the new slot: the moved head at position one, else the new node.
                wr_addr    = r_fidx;
                data_we    = 1'b1;
                link_we    = 1'b1;
                data_wdata = pos_one ? r_head_data : r_value;
                link_wdata = pos_one ? r_head_link : r_plink;
                n_state    = alal_pkg::S_INS_B;
            end

            alal_pkg::S_INS_B: begin
                wr_addr    = pos_one ? '0 : r_pred;
                data_we    = pos_one;
                data_wdata = r_value;
                link_we    = 1'b1;
                link_wdata = LW'(r_fidx);
                n_valid    = 1'b1;
                n_res      = '{alal_pkg::ST_OK, '0, '0, 1'b1};
                n_state    = alal_pkg::S_IDLE;
            end

            alal_pkg::S_TGT: begin
                n_tdata = data_q;
                n_tlink = link_q;
                n_state = alal_pkg::S_DEL_A;
            end

            alal_pkg::S_DEL_A: begin
                // Bypass the target; at position one the successor moves into slot 0.
                wr_addr    = pos_one ? '0 : r_pred;
                data_we    = pos_one;
                data_wdata = r_tdata;
                link_we    = 1'b1;
                link_wdata = r_tlink;
                if (r_tgt >= SlotsW) begin
                    n_valid = 1'b1;
                    n_res   = '{alal_pkg::ST_OK, '0, '0, 1'b1};
                    n_state = alal_pkg::S_IDLE;
                end else begin
                    n_state = alal_pkg::S_DEL_B;
                end
            end

            alal_pkg::S_DEL_B: begin
                wr_addr    = r_tgt[IW-1:0];
                link_we    = 1'b1;
                link_wdata = alal_pkg::LINK_FREE;
                n_valid    = 1'b1;
                n_res      = '{alal_pkg::ST_OK, '0, '0, 1'b1};
                n_state    = alal_pkg::S_IDLE;
            end

            alal_pkg::S_TRAV: begin
                // Emit the node just read; stop at the end mark or after SLOTS nodes.
                n_valid      = 1'b1;
                n_res.status = alal_pkg::ST_OK;
                n_res.value  = data_q;
                n_res.next   = link_q;
                n_res.last   = step.link_end || step.cnt_last;
                if (step.link_end || step.cnt_last) begin
                    n_state = alal_pkg::S_IDLE;
                end else begin
                    rd_addr = link_q[IW-1:0];
                    n_cnt   = step.cnt_inc;
                end
            end

            default: begin
                n_state = alal_pkg::S_IDLE;
            end
        endcase

        // Any slot whose link is written becomes valid.
        if (link_we) begin
            n_vbits[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= alal_pkg::S_IDLE;
            r_vbits  <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_vbits  <= n_vbits;
            r_rd_vld <= r_vbits[rd_addr];
            r_valid  <= n_valid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_value     <= n_value;
        r_pos       <= n_pos;
        r_cur       <= n_cur;
        r_pred      <= n_pred;
        r_plink     <= n_plink;
        r_head_data <= n_head_data;
        r_head_link <= n_head_link;
        r_tgt       <= n_tgt;
        r_tdata     <= n_tdata;
        r_tlink     <= n_tlink;
        r_fidx      <= n_fidx;
        r_res       <= n_res;
    end

endmodule

`default_nettype wire

// ----- src/alal_chk.sv -----
// Port-level checks of the array linked list engine, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module alal_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_status,
    input wire logic        o_last
);

    // An accepted command always keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a command");

    // A traverse stream has no gaps: a non-final result is followed by another.
    a_stream_dense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap in a traverse result stream");

    // The final result ends the command; nothing follows at once.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result right after a final result");

    // An error status is always the single, final result.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != 2'(alal_pkg::ST_OK))) |-> o_last)
        else $error("error status on a non-final result");

    // Only the final result may show while the engine is idle.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result while idle");

endmodule

bind array_linked_list_engine alal_chk u_alal_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_last   (o_last)
);

`default_nettype wire
